FILE: sv/mcvp_pkg.sv
`default_nettype none

package mcvp_pkg;

   localparam logic [7:0] ST_NOTE_OFF = 8'h80;
   localparam logic [7:0] ST_NOTE_ON  = 8'h90;
   localparam logic [7:0] ST_CC       = 8'hB0;
   localparam logic [7:0] ST_PROGRAM  = 8'hC0;
   localparam logic [7:0] ST_BEND     = 8'hE0;
   localparam logic [7:0] ST_IDLE     = 8'h00;

   localparam logic [4:0] REALTIME_PREFIX = 5'h1F;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIDI_CHANNEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEGATO_MODE  = 2'd1;

   localparam logic FUNC_BYTE  = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef struct packed {
      logic [3:0] midi_channel;
      logic       legato_mode;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  status_code;
      logic [3:0]  status_channel;
      logic        fresh_status;
      logic        second_byte_phase;
      logic [6:0]  first_data_byte;
      logic [7:0]  note_count;
      logic [6:0]  active_note_key;
      logic [6:0]  active_note_velocity;
      logic [13:0] bend_register;
      logic [6:0]  program_register;
      logic        trigger_flag;
      logic        stop_flag;
   } state_type;

   typedef struct packed {
      logic        note_triggered;
      logic        note_stopped;
      logic [6:0]  current_key;
      logic [6:0]  current_velocity;
      logic [13:0] bend_value;
      logic [6:0]  program_number;
      logic        cc_event;
      logic [6:0]  cc_number;
      logic [6:0]  cc_value;
      logic [7:0]  held_notes;
   } result_type;

endpackage

`default_nettype wire

FILE: sv/mcvp_decode.sv
`default_nettype none

module mcvp_decode (
   input  wire mcvp_pkg::cfg_type    cfg,
   input  wire mcvp_pkg::state_type  cur,
   input  wire logic                 func,
   input  wire logic [7:0]           midi_byte,
   output mcvp_pkg::state_type       nxt,
   output mcvp_pkg::result_type      res
);

   logic       phase;
   logic [6:0] d;
   logic [7:0] count_inc;
   logic [7:0] count_dec;
   logic       cc_ev;
   logic [6:0] cc_num;
   logic [6:0] cc_val;

   assign phase     = cur.second_byte_phase & ~cur.fresh_status;
   assign d         = midi_byte[6:0];
   assign count_inc = cur.note_count + 8'd1;
   assign count_dec = cur.note_count - 8'd1;

   always_comb begin
      nxt    = cur;
      cc_ev  = 1'b0;
      cc_num = 7'd0;
      cc_val = 7'd0;
      priority if (func == mcvp_pkg::FUNC_CLEAR) begin
         nxt.trigger_flag = 1'b0;
         nxt.stop_flag    = 1'b0;
      end else if (midi_byte[7:3] == mcvp_pkg::REALTIME_PREFIX) begin
         nxt.status_code  = midi_byte;
         nxt.fresh_status = 1'b1;
      end else if (midi_byte[7]) begin
         nxt.status_code    = {midi_byte[7:4], 4'h0};
         nxt.status_channel = midi_byte[3:0];
         nxt.fresh_status   = 1'b1;
      end else if (cur.status_channel == cfg.midi_channel) begin
         unique case (cur.status_code)
            mcvp_pkg::ST_NOTE_ON: begin
               nxt.fresh_status = 1'b0;
               if (!phase) begin
                  nxt.first_data_byte   = d;
                  nxt.second_byte_phase = 1'b1;
               end else begin
                  nxt.second_byte_phase = 1'b0;
                  if (d == 7'd0) begin
                     nxt.note_count = count_dec;
                     if (cur.active_note_key == cur.first_data_byte &&
                         (!cfg.legato_mode || count_dec == 8'd0)) begin
                        nxt.stop_flag = 1'b1;
                     end
                  end else begin
                     nxt.note_count = count_inc;
                     if (!cfg.legato_mode || count_inc == 8'd1) begin
                        nxt.trigger_flag = 1'b1;
                     end
                     nxt.active_note_velocity = d;
                     nxt.active_note_key      = cur.first_data_byte;
                  end
               end
            end
            mcvp_pkg::ST_NOTE_OFF: begin
               nxt.fresh_status = 1'b0;
               if (!phase) begin
                  nxt.first_data_byte   = d;
                  nxt.second_byte_phase = 1'b1;
               end else begin
                  nxt.second_byte_phase = 1'b0;
                  nxt.note_count        = count_dec;
                  if (cur.active_note_key == cur.first_data_byte) begin
                     if (!cfg.legato_mode || count_dec == 8'd0) begin
                        nxt.stop_flag = 1'b1;
                     end
                  end else if (cfg.legato_mode && count_dec == 8'd0) begin
                     nxt.stop_flag = 1'b1;
                  end
               end
            end
            mcvp_pkg::ST_BEND: begin
               nxt.fresh_status = 1'b0;
               if (!phase) begin
                  nxt.bend_register     = {7'd0, d};
                  nxt.second_byte_phase = 1'b1;
               end else begin
                  nxt.bend_register     = {d, cur.bend_register[6:0]};
                  nxt.second_byte_phase = 1'b0;
               end
            end
            mcvp_pkg::ST_CC: begin
               nxt.fresh_status = 1'b0;
               if (!phase) begin
                  nxt.first_data_byte   = d;
                  nxt.second_byte_phase = 1'b1;
               end else begin
                  nxt.second_byte_phase = 1'b0;
                  cc_ev  = 1'b1;
                  cc_num = cur.first_data_byte;
                  cc_val = d;
               end
            end
            mcvp_pkg::ST_PROGRAM: begin
               nxt.fresh_status     = 1'b0;
               nxt.program_register = d;
            end
            default: begin
               nxt = cur;
            end
         endcase
      end
   end

   always_comb begin
      res.note_triggered   = nxt.trigger_flag;
      res.note_stopped     = nxt.stop_flag;
      res.current_key      = nxt.active_note_key;
      res.current_velocity = nxt.active_note_velocity;
      res.bend_value       = nxt.bend_register;
      res.program_number   = nxt.program_register;
      res.cc_event         = cc_ev;
      res.cc_number        = cc_num;
      res.cc_value         = cc_val;
      res.held_notes       = nxt.note_count;
   end

endmodule

`default_nettype wire

FILE: sv/midi_channel_voice_parser_top.sv
// a result is registered when its request beat is accepted
// throughput: one byte or clear command per cycle while req_stall is low
// a two-entry output buffer parks one result in its skid entry while rsp_stall holds
// reset (synchronous, active high) clears all parser state, config and output valids
// idle status is zero and no data byte acts on it
`default_nettype none

module midi_channel_voice_parser_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_func,
   input  wire logic [7:0]                       req_midi_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_note_triggered,
   output logic                                  rsp_note_stopped,
   output logic [6:0]                            rsp_current_key,
   output logic [6:0]                            rsp_current_velocity,
   output logic [13:0]                           rsp_bend_value,
   output logic [6:0]                            rsp_program_number,
   output logic                                  rsp_cc_event,
   output logic [6:0]                            rsp_cc_number,
   output logic [6:0]                            rsp_cc_value,
   output logic [7:0]                            rsp_held_notes,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [mcvp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mcvp_pkg::CSR_DATA_W-1:0]  csr_data
);

   mcvp_pkg::cfg_type    cfg_ff;
   mcvp_pkg::cfg_type    cfg_in;
   mcvp_pkg::state_type  state_ff;
   mcvp_pkg::state_type  state_next;
   mcvp_pkg::state_type  state_in;
   mcvp_pkg::result_type res_new;
   mcvp_pkg::result_type out_ff;
   mcvp_pkg::result_type out_in;
   mcvp_pkg::result_type skid_ff;
   mcvp_pkg::result_type skid_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   logic                 req_accept;
   logic                 out_take;

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid & ~skid_valid_ff;
   assign out_take   = out_valid_ff & ~rsp_stall;

   mcvp_decode u_decode (
      .cfg       (cfg_ff),
      .cur       (state_ff),
      .func      (req_func),
      .midi_byte (req_midi_byte),
      .nxt       (state_next),
      .res       (res_new)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mcvp_pkg::CSR_MIDI_CHANNEL: cfg_in.midi_channel = csr_data[3:0];
            mcvp_pkg::CSR_LEGATO_MODE:  cfg_in.legato_mode  = csr_data[0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   assign state_in = req_accept ? state_next : state_ff;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (!out_valid_ff || out_take) begin
            out_in       = res_new;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res_new;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '0;
         state_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_note_triggered   = out_ff.note_triggered;
   assign rsp_note_stopped     = out_ff.note_stopped;
   assign rsp_current_key      = out_ff.current_key;
   assign rsp_current_velocity = out_ff.current_velocity;
   assign rsp_bend_value       = out_ff.bend_value;
   assign rsp_program_number   = out_ff.program_number;
   assign rsp_cc_event         = out_ff.cc_event;
   assign rsp_cc_number        = out_ff.cc_number;
   assign rsp_cc_value         = out_ff.cc_value;
   assign rsp_held_notes       = out_ff.held_notes;

   // skid entry only exists behind a waiting output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without output beat");

   // skid fills only when the output beat was stalled
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid filled while output was free");

   // parser state moves only on an accepted request beat
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(state_ff))
      else $error("parser state changed without a request beat");

endmodule

`default_nettype wire
